FILE: sv/rfa_pkg.sv
package rfa_pkg;

    // Operation codes; codes 10 to 15 are undefined and give an all-zero result
    typedef enum logic [3:0] {
        MODE_ADD = 4'd0,
        MODE_SUB = 4'd1,
        MODE_MUL = 4'd2,
        MODE_DIV = 4'd3,
        MODE_EQ  = 4'd4,
        MODE_NE  = 4'd5,
        MODE_LT  = 4'd6,
        MODE_GT  = 4'd7,
        MODE_LE  = 4'd8,
        MODE_GE  = 4'd9
    } t_mode;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = WORD_W / 2;

    typedef logic [WORD_W-1:0] t_word;

    // Input transaction
    typedef struct packed {
        logic        [3:0]        mode;
        logic signed [WORD_W-1:0] a_num;
        logic signed [WORD_W-1:0] a_den;
        logic signed [WORD_W-1:0] b_num;
        logic signed [WORD_W-1:0] b_den;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic signed [WORD_W-1:0] res_num;
        logic signed [WORD_W-1:0] res_den;
        logic                     cmp_true;
        logic                     res_is_nan;
        logic                     res_is_inf;
    } t_out_item;

endpackage

FILE: sv/rfa_in_if.sv
interface rfa_in_if import rfa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/rfa_out_if.sv
interface rfa_out_if import rfa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/rfa_mul64.sv
// Low 64 bits of a 64x64 product in two stages:
// three 32x32 partial products, then one combining add.
module rfa_mul64 import rfa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en_part,
    input  logic  i_en_sum,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_p
);

    logic [WORD_W-1:0] r_ll;
    logic [HALF_W-1:0] r_lh;
    logic [HALF_W-1:0] r_hl;
    logic [WORD_W-1:0] r_p;

    logic [WORD_W-1:0] n_ll;
    logic [HALF_W-1:0] n_lh;
    logic [HALF_W-1:0] n_hl;
    logic [HALF_W-1:0] mid;

    // Partial products; only the low half of the cross terms matters
    always_comb begin
        n_ll = i_a[HALF_W-1:0]      * i_b[HALF_W-1:0];
        n_lh = i_a[HALF_W-1:0]      * i_b[WORD_W-1:HALF_W];
        n_hl = i_a[WORD_W-1:HALF_W] * i_b[HALF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en_part) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
        end
    end

    // Combine: cross terms land in the upper half, wrapping mod 2^64
    assign mid = r_lh + r_hl;

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_p <= r_ll + {mid, {HALF_W{1'b0}}};
        end
    end

    assign o_p = r_p;

endmodule

FILE: sv/rational_fraction_alu.sv
// Registered stages: operands, partial products, product combine, numerator/compare, output.
// Throughput: one transaction per cycle while the output accepts; each stage holds while the next is
// full and stalled, so a stall at the output backs up without loss.
// Depth is set by the 64-bit multipliers (partial products, then combine).
// Reset (synchronous, active low) clears the stage valid bits only.
module rational_fraction_alu import rfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rfa_in_if.sink      i_in,
    rfa_out_if.source   o_out
);

    // Stage valid bits and advance enables
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5 = !r5_valid || o_out.ready;
    assign adv4 = !r4_valid || adv5;
    assign adv3 = !r3_valid || adv4;
    assign adv2 = !r2_valid || adv3;
    assign adv1 = !r1_valid || adv2;

    assign i_in.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (adv1) r1_valid <= i_in.valid;
            if (adv2) r2_valid <= r1_valid;
            if (adv3) r3_valid <= r2_valid;
            if (adv4) r4_valid <= r3_valid;
            if (adv5) r5_valid <= r4_valid;
        end
    end

    // Stage 1: register operands, choosing multiplier inputs by mode
    t_mode r1_mode, r2_mode, r3_mode;
    t_word r1_x_a, r1_x_b, r1_y_a, r1_y_b, r1_z_a, r1_z_b;
    t_mode n1_mode;

    assign n1_mode = t_mode'(i_in.data.mode);

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_mode <= n1_mode;
            r1_x_a  <= i_in.data.a_num;
            r1_x_b  <= (n1_mode == MODE_MUL) ? i_in.data.b_num : i_in.data.b_den;
            r1_y_a  <= i_in.data.b_num;
            r1_y_b  <= i_in.data.a_den;
            r1_z_a  <= i_in.data.a_den;
            r1_z_b  <= (n1_mode == MODE_DIV) ? i_in.data.b_num : i_in.data.b_den;
        end
    end

    // Stages 2-3: three product units
    t_word p_x, p_y, p_z;

    rfa_mul64 u_mul_x (
        .i_clk     (i_clk),
        .i_en_part (adv2),
        .i_en_sum  (adv3),
        .i_a       (r1_x_a),
        .i_b       (r1_x_b),
        .o_p       (p_x)
    );

    rfa_mul64 u_mul_y (
        .i_clk     (i_clk),
        .i_en_part (adv2),
        .i_en_sum  (adv3),
        .i_a       (r1_y_a),
        .i_b       (r1_y_b),
        .o_p       (p_y)
    );

    rfa_mul64 u_mul_z (
        .i_clk     (i_clk),
        .i_en_part (adv2),
        .i_en_sum  (adv3),
        .i_a       (r1_z_a),
        .i_b       (r1_z_b),
        .o_p       (p_z)
    );

    always_ff @(posedge i_clk) begin
        if (adv2) r2_mode <= r1_mode;
        if (adv3) r3_mode <= r2_mode;
    end

    // Stage 4: numerator sum, difference or product pass-through, cross-product compare
    t_word n4_rn, n4_rd;
    logic  n4_cmp, n4_arith;
    logic  eq_xy, lt_xy, lt_yx;
    t_word r4_rn, r4_rd;
    logic  r4_cmp, r4_arith;

    assign eq_xy = (p_x == p_y);
    assign lt_xy = ($signed(p_x) < $signed(p_y));
    assign lt_yx = ($signed(p_y) < $signed(p_x));

    always_comb begin
        n4_rn    = '0;
        n4_rd    = '0;
        n4_cmp   = 1'b0;
        n4_arith = 1'b0;
        unique case (r3_mode)
            MODE_ADD: begin
                n4_rn    = p_x + p_y;
                n4_rd    = p_z;
                n4_arith = 1'b1;
            end
            MODE_SUB: begin
                n4_rn    = p_x - p_y;
                n4_rd    = p_z;
                n4_arith = 1'b1;
            end
            MODE_MUL, MODE_DIV: begin
                n4_rn    = p_x;
                n4_rd    = p_z;
                n4_arith = 1'b1;
            end
            MODE_EQ: n4_cmp = eq_xy;
            MODE_NE: n4_cmp = !eq_xy;
            MODE_LT: n4_cmp = lt_xy;
            MODE_GT: n4_cmp = lt_yx;
            MODE_LE: n4_cmp = !lt_yx;
            MODE_GE: n4_cmp = !lt_xy;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r4_rn    <= n4_rn;
            r4_rd    <= n4_rd;
            r4_cmp   <= n4_cmp;
            r4_arith <= n4_arith;
        end
    end

    // Stage 5: zero detection for NaN and infinity, output register
    t_out_item r5_item;
    logic      num_zero, den_zero;

    assign num_zero = (r4_rn == '0);
    assign den_zero = (r4_rd == '0);

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r5_item.res_num    <= r4_rn;
            r5_item.res_den    <= r4_rd;
            r5_item.cmp_true   <= r4_cmp;
            r5_item.res_is_nan <= r4_arith && num_zero && den_zero;
            r5_item.res_is_inf <= r4_arith && !num_zero && den_zero;
        end
    end

    assign o_out.valid = r5_valid;
    assign o_out.data  = r5_item;

endmodule
